/* sv/slt_pkg.sv */
// slt_pkg: shared types, codes and constants of the shell line tokenizer
// used by every module of the block; no dependencies
`timescale 1ns / 1ps

package slt_pkg;

   // fixed field widths
   localparam int CHAR_W       = 8;
   localparam int POS_W        = 10;
   localparam int MAX_LINE_DEF = 1024;

   // results one request can cause (a pending '>' only lives in the blank state)
   localparam int SLOTS        = 2;
   localparam int CNT_W        = 2;

   // bundle queue between front and back
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = 2;
   localparam int QCNT_W       = 3;

   // characters the lexer looks at
   localparam logic [CHAR_W-1:0] CH_PIPE  = 8'h7C;
   localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
   localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
   localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;

   typedef enum logic [1:0] {
      LEX_SKIP   = 2'd0,
      LEX_WORD   = 2'd1,
      LEX_QUOTED = 2'd2
   } lex_state_type;

   typedef enum logic [2:0] {
      EV_CHAR   = 3'd0,
      EV_END    = 3'd1,
      EV_OP     = 3'd2,
      EV_UNTERM = 3'd3,
      EV_DONE   = 3'd4
   } event_type;

   typedef enum logic [2:0] {
      TT_WORD   = 3'd0,
      TT_QUOTED = 3'd1,
      TT_PIPE   = 3'd2,
      TT_IN     = 3'd3,
      TT_OUT    = 3'd4,
      TT_APPEND = 3'd5
   } token_kind_type;

   typedef enum logic {
      MODE_CHAR = 1'b0,
      MODE_EOL  = 1'b1
   } mode_type;

   // one result item without its last flag
   typedef struct packed {
      event_type         event_res;
      token_kind_type    token_type;
      logic [CHAR_W-1:0] char_code_res;
      logic [POS_W-1:0]  position;
      logic              illegal;
   } result_type;

   // all results of one request
   typedef struct packed {
      logic [CNT_W-1:0]        count;
      result_type [SLOTS-1:0]  recs;
   } bundle_type;

   // front lexer status, watched at the top
   typedef struct packed {
      lex_state_type lex_state;
      logic          pending_gt;
   } front_status_type;

   // word characters: alphanumeric or one of - _ . / \ : ~
   function automatic logic allowed_char(input logic [CHAR_W-1:0] c);
      logic ok;
      ok = 1'b0;
      if (c >= 8'h30 && c <= 8'h39) ok = 1'b1;
      if (c >= 8'h41 && c <= 8'h5A) ok = 1'b1;
      if (c >= 8'h61 && c <= 8'h7A) ok = 1'b1;
      if (c == 8'h2D || c == 8'h5F || c == 8'h2E || c == 8'h2F ||
          c == 8'h5C || c == 8'h3A || c == 8'h7E) ok = 1'b1;
      return ok;
   endfunction

endpackage

/* sv/slt_front.sv */
// slt_front: lexer front end, classifies each request into a result bundle
// depends on slt_pkg
`timescale 1ns / 1ps

module slt_front
   import slt_pkg::*;
#(
   parameter int MAX_LINE = MAX_LINE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              mode,
   input  logic [CHAR_W-1:0] char_code,
   output logic              push,
   output bundle_type        bundle,
   output front_status_type  status
);

   localparam int PW = $clog2(MAX_LINE);

   lex_state_type   state_ff, state_in;
   logic            pend_ff, pend_in;
   logic [PW-1:0]   pend_pos_ff, pend_pos_in;
   logic [PW-1:0]   tok_ff, tok_in;
   logic [PW-1:0]   cpos_ff, cpos_in;

   logic blank, quote, op, is_gt, consumed, delim;

   // character classes
   assign blank    = (char_code == CH_SPACE) || (char_code == CH_TAB);
   assign quote    = (char_code == CH_QUOTE);
   assign is_gt    = (char_code == CH_GT);
   assign op       = (char_code == CH_PIPE) || (char_code == CH_LT) || is_gt;
   assign delim    = blank || quote || op;
   assign consumed = pend_ff && is_gt;

   // next lexer state
   always_comb begin
      state_in = state_ff;
      if (mode == MODE_EOL) begin
         state_in = LEX_SKIP;
      end else if (!consumed) begin
         unique case (state_ff)
            LEX_QUOTED: begin
               if (quote) state_in = LEX_SKIP;
            end
            LEX_SKIP, LEX_WORD: begin
               if (quote) state_in = LEX_QUOTED;
               else if (delim) state_in = LEX_SKIP;
               else state_in = LEX_WORD;
            end
            default: state_in = LEX_SKIP;
         endcase
      end
   end

   // side registers: pending '>', token start, position
   always_comb begin
      pend_in     = pend_ff;
      pend_pos_in = pend_pos_ff;
      tok_in      = tok_ff;
      cpos_in     = cpos_ff;
      if (mode == MODE_EOL) begin
         pend_in     = 1'b0;
         pend_pos_in = '0;
         tok_in      = '0;
         cpos_in     = '0;
      end else begin
         pend_in = 1'b0;
         if (!consumed && state_ff != LEX_QUOTED) begin
            if (quote) begin
               tok_in = cpos_ff;
            end else if (is_gt) begin
               pend_in     = 1'b1;
               pend_pos_in = cpos_ff;
            end else if (!blank && !op && state_ff != LEX_WORD) begin
               tok_in = cpos_ff;
            end
         end
         if (cpos_ff < PW'(MAX_LINE - 1)) cpos_in = cpos_ff + 1'b1;
      end
   end

   // result bundle for this request
   always_comb begin
      result_type       r;
      logic [CNT_W-1:0] n;
      r      = '0;
      n      = '0;
      bundle = '0;
      if (mode == MODE_EOL) begin
         if (pend_ff) begin
            r = '{EV_OP, TT_OUT, '0, POS_W'(pend_pos_ff), 1'b0};
            bundle.recs[n[0]] = r;
            n = n + 1'b1;
         end else if (state_ff == LEX_WORD) begin
            r = '{EV_END, TT_WORD, '0, POS_W'(tok_ff), 1'b0};
            bundle.recs[n[0]] = r;
            n = n + 1'b1;
         end else if (state_ff == LEX_QUOTED) begin
            r = '{EV_UNTERM, TT_QUOTED, '0, POS_W'(tok_ff), 1'b0};
            bundle.recs[n[0]] = r;
            n = n + 1'b1;
         end
         r = '{EV_DONE, TT_WORD, '0, POS_W'(cpos_ff), 1'b0};
         bundle.recs[n[0]] = r;
         n = n + 1'b1;
      end else begin
         if (pend_ff) begin
            r = '{EV_OP, is_gt ? TT_APPEND : TT_OUT, '0, POS_W'(pend_pos_ff), 1'b0};
            bundle.recs[n[0]] = r;
            n = n + 1'b1;
         end
         if (!consumed) begin
            if (state_ff == LEX_QUOTED) begin
               if (quote) r = '{EV_END, TT_QUOTED, '0, POS_W'(tok_ff), 1'b0};
               else r = '{EV_CHAR, TT_QUOTED, char_code, POS_W'(cpos_ff), 1'b0};
               bundle.recs[n[0]] = r;
               n = n + 1'b1;
            end else begin
               if (state_ff == LEX_WORD && delim) begin
                  r = '{EV_END, TT_WORD, '0, POS_W'(tok_ff), 1'b0};
                  bundle.recs[n[0]] = r;
                  n = n + 1'b1;
               end
               if (char_code == CH_PIPE) begin
                  r = '{EV_OP, TT_PIPE, '0, POS_W'(cpos_ff), 1'b0};
                  bundle.recs[n[0]] = r;
                  n = n + 1'b1;
               end else if (char_code == CH_LT) begin
                  r = '{EV_OP, TT_IN, '0, POS_W'(cpos_ff), 1'b0};
                  bundle.recs[n[0]] = r;
                  n = n + 1'b1;
               end else if (!delim) begin
                  r = '{EV_CHAR, TT_WORD, char_code, POS_W'(cpos_ff),
                        !allowed_char(char_code)};
                  bundle.recs[n[0]] = r;
                  n = n + 1'b1;
               end
            end
         end
      end
      bundle.count = n;
   end

   assign push   = accept && (bundle.count != '0);
   assign status = '{state_ff, pend_ff};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= LEX_SKIP;
         pend_ff     <= 1'b0;
         pend_pos_ff <= '0;
         tok_ff      <= '0;
         cpos_ff     <= '0;
      end else if (accept) begin
         state_ff    <= state_in;
         pend_ff     <= pend_in;
         pend_pos_ff <= pend_pos_in;
         tok_ff      <= tok_in;
         cpos_ff     <= cpos_in;
      end
   end

endmodule

/* sv/slt_queue.sv */
// slt_queue: short queue of result bundles between front and back
// depends on slt_pkg
`timescale 1ns / 1ps

module slt_queue
   import slt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bundle_type        push_data,
   input  logic              pop,
   output bundle_type        head,
   output logic              not_empty,
   output logic              full,
   output logic [QCNT_W-1:0] level
);

   bundle_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, rd_ff;
   logic [QCNT_W-1:0]  cnt_ff;

   assign head      = mem_ff[rd_ff];
   assign not_empty = (cnt_ff != '0);
   assign full      = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign level     = cnt_ff;

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

endmodule

/* sv/slt_back.sv */
// slt_back: walks through each bundle and drives the result register
// depends on slt_pkg
`timescale 1ns / 1ps

module slt_back
   import slt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  bundle_type head,
   input  logic       head_valid,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_rec,
   output logic       out_last
);

   logic       sel_ff;
   logic       valid_ff;
   result_type rec_ff;
   logic       last_ff;
   logic       load, is_last;

   // next result may load when the register is free or being taken
   assign load    = head_valid && (!valid_ff || out_ready);
   assign is_last = (head.count == CNT_W'(1)) || sel_ff;
   assign pop     = load && is_last;

   // slot select and valid
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (load) sel_ff <= !is_last;
         if (load) valid_ff <= 1'b1;
         else if (out_ready) valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         rec_ff  <= head.recs[sel_ff];
         last_ff <= is_last;
      end
   end

   assign out_valid = valid_ff;
   assign out_rec   = rec_ff;
   assign out_last  = last_ff;

endmodule

/* sv/shell_line_tokenizer.sv */
// shell_line_tokenizer: top level of the command line lexer
// depends on slt_pkg, slt_front, slt_queue, slt_back
//
//   channel   dir   payload
//   req_*     in    tuser[0] mode, tdata[7:0] char_code
//   rsp_*     out   tuser[2:0] event_res, tdata token fields, tlast last
//
// a request is classified in the cycle it is accepted; one request per cycle
// while the bundle queue has room. results leave one per cycle while
// rsp_tready is high; a request causing two results sends them in turn from
// the result register, after passing through the bundle queue storage.
// synchronous reset returns the lexer to the blank state and empties the queue.
// a stall on rsp_tready backs up into the queue, then req_tready drops.
`timescale 1ns / 1ps

module shell_line_tokenizer
   import slt_pkg::*;
#(
   parameter int MAX_LINE = MAX_LINE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic [0:0]  req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] token_type, [10:3] char_code_res, [20:11] position, [21] illegal
   output logic [23:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,   // [2:0] event_res
   output logic        rsp_tlast
);

   logic              accept, push, pop, q_valid, q_full;
   logic [QCNT_W-1:0] q_level;
   bundle_type        push_bundle, head;
   front_status_type  front_status;
   result_type        out_rec;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   slt_front #(
      .MAX_LINE (MAX_LINE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .mode      (req_tuser[0]),
      .char_code (req_tdata),
      .push      (push),
      .bundle    (push_bundle),
      .status    (front_status)
   );

   slt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_bundle),
      .pop       (pop),
      .head      (head),
      .not_empty (q_valid),
      .full      (q_full),
      .level     (q_level)
   );

   slt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (q_valid),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_rec    (out_rec),
      .out_last   (rsp_tlast)
   );

   // pack result fields
   assign rsp_tuser = out_rec.event_res;
   assign rsp_tdata = {2'b00, out_rec.illegal, out_rec.position,
                       out_rec.char_code_res, out_rec.token_type};

   // queue never written while full
   assert property (@(posedge clock) disable iff (reset) q_full |-> !push)
      else $error("bundle pushed into a full queue");

   // fill level stays within depth
   assert property (@(posedge clock) disable iff (reset)
      q_level <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue level beyond depth");

   // end of line returns the lexer to the blank state with nothing pending
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser[0]) |=>
         (front_status.lex_state == LEX_SKIP && !front_status.pending_gt))
      else $error("lexer not cleared after end of line");

   // a pending '>' only exists outside tokens
   assert property (@(posedge clock) disable iff (reset)
      front_status.pending_gt |-> front_status.lex_state == LEX_SKIP)
      else $error("pending redirect inside a token");

endmodule

/* tb/shell_line_tokenizer_tb.sv */
// shell_line_tokenizer_tb: self-checking bench for the command line lexer
// drives a directed table and random command lines, predicts every result in
// the bench; depends on slt_pkg and shell_line_tokenizer
`timescale 1ns / 1ps

module shell_line_tokenizer_tb;
   import slt_pkg::*;

   localparam int LINE_MAX       = MAX_LINE_DEF;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 16;
   localparam int BATCH_ITEMS    = 80;
   localparam int REPORT_MAX     = 10;

   // one result as it travels on the rsp channel
   typedef struct packed {
      event_type         ev;
      token_kind_type    kind;
      logic [CHAR_W-1:0] ch;
      logic [POS_W-1:0]  pos;
      logic              bad;
      logic              last;
   } lex_result_type;

   // one row of the directed table
   typedef struct {
      mode_type          mode;
      logic [CHAR_W-1:0] ch;
      logic              typed;
      lex_result_type    want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] char_code
   logic [0:0]  req_tuser = 1'b0;    // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [2:0] token_type, [10:3] char_code_res, [20:11] position, [21] illegal
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;           // [2:0] event_res
   logic        rsp_tlast;

   // lexer copy kept by the bench
   lex_state_type     lex_st;
   logic              gt_pending;
   logic [POS_W-1:0]  gt_pos;
   logic [POS_W-1:0]  tok_start;
   int                char_pos;

   lex_result_type expected_results[$];
   stim_row_type   directed_rows[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int requests_sent = 0;
   int results_seen  = 0;
   int lines_sent    = 0;
   int errors        = 0;
   int quiet_cycles  = 0;

   shell_line_tokenizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic is_word_char(input logic [7:0] c);
      // alphanumeric or one of - _ . / \ : ~
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A) || c == 8'h2D || c == 8'h5F ||
             c == 8'h2E || c == 8'h2F || c == 8'h5C || c == 8'h3A || c == 8'h7E;
   endfunction

   function automatic logic is_special(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_QUOTE ||
             c == CH_PIPE || c == CH_LT || c == CH_GT;
   endfunction

   task automatic clear_lexer();
      lex_st     = LEX_SKIP;
      gt_pending = 1'b0;
      gt_pos     = '0;
      tok_start  = '0;
      char_pos   = 0;
   endtask

   task automatic note_result(input event_type ev, input token_kind_type kind,
                              input logic [7:0] ch, input logic [POS_W-1:0] pos,
                              input logic bad);
      lex_result_type r;
      r.ev   = ev;
      r.kind = kind;
      r.ch   = ch;
      r.pos  = pos;
      r.bad  = bad;
      r.last = 1'b0;
      expected_results.insert(expected_results.size(), r);
   endtask

   // results caused by one accepted request
   task automatic predict_request(input mode_type m, input logic [7:0] c);
      int               base;
      logic             blank;
      logic             quote;
      logic             op;
      logic             taken;
      logic [POS_W-1:0] p;
      base  = expected_results.size();
      p     = char_pos[POS_W-1:0];
      blank = (c == CH_SPACE || c == CH_TAB);
      quote = (c == CH_QUOTE);
      op    = (c == CH_PIPE || c == CH_LT || c == CH_GT);
      taken = 1'b0;
      if (m == MODE_EOL) begin
         if (gt_pending)
            note_result(EV_OP, TT_OUT, 8'h00, gt_pos, 1'b0);
         else if (lex_st == LEX_WORD)
            note_result(EV_END, TT_WORD, 8'h00, tok_start, 1'b0);
         else if (lex_st == LEX_QUOTED)
            note_result(EV_UNTERM, TT_QUOTED, 8'h00, tok_start, 1'b0);
         note_result(EV_DONE, TT_WORD, 8'h00, p, 1'b0);
         clear_lexer();
      end else begin
         // held '>' resolves first
         if (gt_pending) begin
            gt_pending = 1'b0;
            if (c == CH_GT) begin
               note_result(EV_OP, TT_APPEND, 8'h00, gt_pos, 1'b0);
               taken = 1'b1;
            end else begin
               note_result(EV_OP, TT_OUT, 8'h00, gt_pos, 1'b0);
            end
         end
         if (!taken) begin
            if (lex_st == LEX_QUOTED) begin
               if (quote) begin
                  note_result(EV_END, TT_QUOTED, 8'h00, tok_start, 1'b0);
                  lex_st = LEX_SKIP;
               end else begin
                  note_result(EV_CHAR, TT_QUOTED, c, p, 1'b0);
               end
            end else begin
               if (lex_st == LEX_WORD && (blank || quote || op)) begin
                  note_result(EV_END, TT_WORD, 8'h00, tok_start, 1'b0);
                  lex_st = LEX_SKIP;
               end
               if (blank) begin
                  // dropped outside quotes
               end else if (quote) begin
                  lex_st    = LEX_QUOTED;
                  tok_start = p;
               end else if (c == CH_PIPE) begin
                  note_result(EV_OP, TT_PIPE, 8'h00, p, 1'b0);
               end else if (c == CH_LT) begin
                  note_result(EV_OP, TT_IN, 8'h00, p, 1'b0);
               end else if (c == CH_GT) begin
                  gt_pending = 1'b1;
                  gt_pos     = p;
               end else begin
                  if (lex_st != LEX_WORD) begin
                     lex_st    = LEX_WORD;
                     tok_start = p;
                  end
                  note_result(EV_CHAR, TT_WORD, c, p, !is_word_char(c));
               end
            end
         end
         if (char_pos < LINE_MAX - 1) char_pos++;
      end
      if (expected_results.size() > base)
         expected_results[expected_results.size()-1].last = 1'b1;
   endtask

   // ---------------------------------------------------------------- driver

   // returns once the request has been taken at a clock edge
   task automatic send_request(input mode_type m, input logic [7:0] c);
      logic ok;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= m;
      do begin
         @(negedge clock);
         ok = req_tready;
         @(posedge clock);
      end while (!ok);
      predict_request(m, c);
      requests_sent++;
   endtask

   function automatic logic [7:0] pick_word_char();
      logic [7:0] c;
      case ($urandom_range(0, 9))
         0, 1, 2: c = 8'h61 + 8'($urandom_range(0, 25));
         3:       c = 8'h41 + 8'($urandom_range(0, 25));
         4:       c = 8'h30 + 8'($urandom_range(0, 9));
         5: begin
            case ($urandom_range(0, 6))
               0:       c = 8'h2D;
               1:       c = 8'h5F;
               2:       c = 8'h2E;
               3:       c = 8'h2F;
               4:       c = 8'h5C;
               5:       c = 8'h3A;
               default: c = 8'h7E;
            endcase
         end
         6: begin
            // any byte that stays inside the word, often illegal
            c = 8'($urandom_range(0, 255));
            if (is_special(c)) c = 8'h21;
         end
         default: c = 8'h61 + 8'($urandom_range(0, 25));
      endcase
      return c;
   endfunction

   function automatic logic [7:0] pick_quoted_char();
      logic [7:0] c;
      case ($urandom_range(0, 9))
         0:       c = CH_SPACE;
         1:       c = CH_TAB;
         2:       c = CH_PIPE;
         3:       c = CH_GT;
         default: c = 8'($urandom_range(0, 255));
      endcase
      if (c == CH_QUOTE) c = 8'h27;
      return c;
   endfunction

   function automatic logic [7:0] pick_noise_char();
      logic [7:0] c;
      case ($urandom_range(0, 11))
         0:       c = CH_SPACE;
         1:       c = CH_TAB;
         2:       c = CH_QUOTE;
         3:       c = CH_PIPE;
         4:       c = CH_LT;
         5, 6:    c = CH_GT;
         default: c = 8'($urandom_range(0, 255));
      endcase
      return c;
   endfunction

   // one random command line, mostly well formed
   task automatic send_line();
      int ntok;
      int k;
      int j;
      int n;
      lines_sent++;
      if ($urandom_range(0, 9) == 0) begin
         // noise: raw bytes and stray end-of-line marks
         n = $urandom_range(1, 8);
         for (j = 0; j < n; j++) begin
            if ($urandom_range(0, 5) == 0)
               send_request(MODE_EOL, 8'($urandom_range(0, 255)));
            else
               send_request(MODE_CHAR, pick_noise_char());
         end
         return;
      end
      ntok = $urandom_range(1, 6);
      for (k = 0; k < ntok; k++) begin
         // separators, none at times so tokens touch
         n = $urandom_range(0, 2);
         for (j = 0; j < n; j++)
            send_request(MODE_CHAR, ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB);
         case ($urandom_range(0, 5))
            0, 1, 2: begin
               n = $urandom_range(1, 5);
               for (j = 0; j < n; j++) send_request(MODE_CHAR, pick_word_char());
            end
            3: begin
               send_request(MODE_CHAR, CH_QUOTE);
               n = $urandom_range(0, 4);
               for (j = 0; j < n; j++) send_request(MODE_CHAR, pick_quoted_char());
               if ($urandom_range(0, 5) != 0) send_request(MODE_CHAR, CH_QUOTE);
            end
            default: begin
               case ($urandom_range(0, 3))
                  0: send_request(MODE_CHAR, CH_PIPE);
                  1: send_request(MODE_CHAR, CH_LT);
                  2: send_request(MODE_CHAR, CH_GT);
                  default: begin
                     send_request(MODE_CHAR, CH_GT);
                     send_request(MODE_CHAR, CH_GT);
                  end
               endcase
            end
         endcase
      end
      // a line left open runs on into the next one
      if ($urandom_range(0, 4) != 0)
         send_request(MODE_EOL, 8'($urandom_range(0, 255)));
   endtask

   task automatic add_row(input mode_type m, input logic [7:0] c);
      stim_row_type row;
      row.mode  = m;
      row.ch    = c;
      row.typed = 1'b0;
      row.want  = '0;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // row whose single result is written out by hand
   task automatic add_typed(input mode_type m, input logic [7:0] c, input event_type ev,
                            input token_kind_type kind, input logic [7:0] ch,
                            input logic [POS_W-1:0] pos, input logic bad);
      stim_row_type row;
      row.mode      = m;
      row.ch        = c;
      row.typed     = 1'b1;
      row.want.ev   = ev;
      row.want.kind = kind;
      row.want.ch   = ch;
      row.want.pos  = pos;
      row.want.bad  = bad;
      row.want.last = 1'b1;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // ---------------------------------------------------------------- monitor

   // sampled mid-cycle, so values are those seen at the next rising edge
   always @(negedge clock) begin
      lex_result_type got;
      lex_result_type want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results still due",
                     WATCHDOG_LIMIT, expected_results.size());
            $display("Some tests failed");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.ev   = event_type'(rsp_tuser);
            got.kind = token_kind_type'(rsp_tdata[2:0]);
            got.ch   = rsp_tdata[10:3];
            got.pos  = rsp_tdata[20:11];
            got.bad  = rsp_tdata[21];
            got.last = rsp_tlast;
            results_seen++;
            if (expected_results.size() == 0) begin
               errors++;
               if (errors <= REPORT_MAX)
                  $display("unexpected result ev=%0d kind=%0d ch=%02h pos=%0d bad=%0b last=%0b",
                           got.ev, got.kind, got.ch, got.pos, got.bad, got.last);
            end else begin
               want = expected_results.pop_front();
               if (got !== want || rsp_tdata[23:22] !== 2'b00) begin
                  errors++;
                  if (errors <= REPORT_MAX)
                     $display({"result %0d mismatch: expected ev=%0d kind=%0d ch=%02h pos=%0d ",
                               "bad=%0b last=%0b, got ev=%0d kind=%0d ch=%02h pos=%0d bad=%0b ",
                               "last=%0b pad=%0b"},
                              results_seen, want.ev, want.kind, want.ch, want.pos, want.bad,
                              want.last, got.ev, got.kind, got.ch, got.pos, got.bad,
                              got.last, rsp_tdata[23:22]);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int i;
      int start;
      clear_lexer();

      // directed table, written from reset onward
      add_typed(MODE_CHAR, 8'h61, EV_CHAR, TT_WORD, 8'h61, 10'd0, 1'b0);
      add_typed(MODE_CHAR, 8'h00, EV_CHAR, TT_WORD, 8'h00, 10'd1, 1'b1);
      add_typed(MODE_CHAR, 8'hFF, EV_CHAR, TT_WORD, 8'hFF, 10'd2, 1'b1);
      add_row(MODE_CHAR, CH_SPACE);       // blank ends the word
      add_row(MODE_CHAR, CH_PIPE);
      add_row(MODE_CHAR, CH_LT);
      add_row(MODE_CHAR, CH_GT);          // held
      add_row(MODE_CHAR, CH_GT);          // becomes append
      add_row(MODE_CHAR, CH_GT);          // held again
      add_row(MODE_CHAR, 8'h78);          // flushes redirect out, then a word
      add_row(MODE_CHAR, CH_QUOTE);       // quote inside a word
      add_row(MODE_CHAR, CH_TAB);         // blank kept in quotes
      add_row(MODE_CHAR, CH_PIPE);        // operator kept in quotes
      add_row(MODE_CHAR, CH_QUOTE);
      add_row(MODE_CHAR, 8'h62);
      add_row(MODE_CHAR, CH_PIPE);        // operator inside a word
      add_row(MODE_CHAR, CH_GT);
      add_row(MODE_EOL, 8'h00);           // end of line with '>' held
      add_row(MODE_CHAR, CH_TAB);         // silent blank
      add_row(MODE_CHAR, CH_QUOTE);       // silent opening quote
      add_row(MODE_CHAR, 8'h71);
      add_row(MODE_EOL, 8'h5A);           // unterminated quote
      add_typed(MODE_EOL, 8'hFF, EV_DONE, TT_WORD, 8'h00, 10'd0, 1'b0);
      add_row(MODE_CHAR, 8'h7A);
      add_row(MODE_EOL, 8'hA5);           // end of line closes the word

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver heavily
      send_idle_pct = 28;
      recv_idle_pct = 74;
      for (i = 0; i < directed_rows.size(); i++) begin
         send_request(directed_rows[i].mode, directed_rows[i].ch);
         if (directed_rows[i].typed)
            expected_results[expected_results.size()-1] = directed_rows[i].want;
      end
      start = requests_sent;
      while (requests_sent - start < BATCH_ITEMS) send_line();

      // the other way round
      send_idle_pct = 74;
      recv_idle_pct = 28;
      start = requests_sent;
      while (requests_sent - start < BATCH_ITEMS) send_line();

      // no idling at all
      send_idle_pct = 0;
      recv_idle_pct = 0;
      start = requests_sent;
      while (requests_sent - start < BATCH_ITEMS) send_line();
      send_request(MODE_EOL, 8'h00);
      req_tvalid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      errors += expected_results.size();

      $display("%0d requests in %0d lines plus a directed table, %0d results checked",
               requests_sent, lines_sent, results_seen);
      $display("idle patterns: light/heavy, heavy/light, none; %0d failures", errors);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
